/* hdl/mfdrq_pkg.sv */
// Shared types and constants for the multiplexed frame deframer with receive queue.
`timescale 1ns / 1ps

package mfdrq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 256;

    localparam logic [7:0] SOF_BYTE  = 8'hBF;
    localparam logic [7:0] LINK_NONE = 8'hFF;

    // Command codes carried on the request channel.
    localparam logic [1:0] CMD_LINK_BYTE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE   = 2'd1;
    localparam logic [1:0] CMD_CLEAR     = 2'd2;
    localparam logic [1:0] CMD_NOP       = 2'd3;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] frame_link;
        logic       dropped;
        logic       read_valid;
        logic [7:0] read_data;
    } rsp_t;

endpackage

/* hdl/mfdrq_req_if.sv */
// Request channel: command and link byte with a valid/ready handshake.
`timescale 1ns / 1ps

interface mfdrq_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] line_byte;

    modport source (output valid, output cmd, output line_byte, input ready);
    modport sink (input valid, input cmd, input line_byte, output ready);
endinterface

/* hdl/mfdrq_rsp_if.sv */
// Result channel: payload echo, frame link and dequeue data with a valid/ready handshake.
`timescale 1ns / 1ps

interface mfdrq_rsp_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] frame_link;
    logic       dropped;
    logic       read_valid;
    logic [7:0] read_data;

    modport source (
        output valid, output payload_valid, output payload_byte, output frame_link,
        output dropped, output read_valid, output read_data, input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte, input frame_link,
        input dropped, input read_valid, input read_data, output ready
    );
endinterface

/* hdl/mux_frame_deframer_rx_queue.sv */
// Top level: frame deframer state machine with a ring queue of received payload bytes.
//
//   channel | dir | beat contents
//   --------+-----+--------------------------------------------------------------
//   req     | in  | cmd, line_byte
//   rsp     | out | payload_valid, payload_byte, frame_link, dropped,
//           |     | read_valid, read_data
//
// One request beat is taken per cycle while the result stage can pass its beat on.
// Accepting a beat updates the deframer and the queue and reads the queue memory
// into a register; the output register then holds the finished result for the output port.
// A result stage and an output register let a new beat in while a result waits.
// Reset returns the deframer to hunting for a start byte and empties the queue.
`timescale 1ns / 1ps

module mux_frame_deframer_rx_queue #(
    parameter int QUEUE_DEPTH = mfdrq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    mfdrq_req_if.sink   req,
    mfdrq_rsp_if.source rsp
);
    import mfdrq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_LINK,
        PH_FLAGS,
        PH_LEN,
        PH_PAYLOAD,
        PH_FOOTER
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [7:0]       left_reg, left_next;
    logic [7:0]       link_reg, link_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;

    logic [7:0]       queue_mem [QUEUE_DEPTH];
    logic [7:0]       rd_data_reg;

    logic             accept;
    logic             do_write;
    logic             do_read;
    logic             queue_empty;
    logic             queue_full;

    rsp_t             res_next;
    rsp_t             res_reg;
    logic             res_valid_reg;
    rsp_t             out_reg;
    logic             out_valid_reg;
    logic             move;
    rsp_t             res_done;

    assign wr_ptr_inc  = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc  = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign queue_empty = (wr_ptr_reg == rd_ptr_reg);
    assign queue_full  = (wr_ptr_inc == rd_ptr_reg);

    assign move      = res_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !res_valid_reg || move;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        link_next   = link_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        do_write    = 1'b0;
        do_read     = 1'b0;
        res_next    = '0;

        unique case (req.cmd)
            CMD_LINK_BYTE:
            begin
                case (phase_reg)
                    PH_LINK:
                    begin
                        link_next  = req.line_byte;
                        phase_next = PH_FLAGS;
                    end
                    PH_FLAGS:
                    begin
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        left_next  = req.line_byte;
                        phase_next = (req.line_byte == 8'd0) ? PH_FOOTER : PH_PAYLOAD;
                    end
                    PH_PAYLOAD:
                    begin
                        res_next.payload_valid = 1'b1;
                        res_next.payload_byte  = req.line_byte;
                        if (queue_full)
                        begin
                            res_next.dropped = 1'b1;
                        end
                        else
                        begin
                            do_write    = 1'b1;
                            wr_ptr_next = wr_ptr_inc;
                        end
                        left_next = left_reg - 8'd1;
                        if (left_reg == 8'd1)
                        begin
                            phase_next = PH_FOOTER;
                        end
                    end
                    PH_FOOTER:
                    begin
                        phase_next = PH_WAIT;
                        link_next  = LINK_NONE;
                    end
                    default:
                    begin
                        phase_next = (req.line_byte == SOF_BYTE) ? PH_LINK : PH_WAIT;
                    end
                endcase
            end
            CMD_DEQUEUE:
            begin
                if (!queue_empty)
                begin
                    do_read     = 1'b1;
                    rd_ptr_next = rd_ptr_inc;
                end
            end
            CMD_CLEAR:
            begin
                wr_ptr_next = '0;
                rd_ptr_next = '0;
            end
            CMD_NOP:
            begin
            end
            default:
            begin
            end
        endcase

        res_next.frame_link = link_next;
        res_next.read_valid = do_read;
    end

    // The dequeued byte arrives from the memory in the cycle after the request beat.
    always_comb
    begin
        res_done           = res_reg;
        res_done.read_data = res_reg.read_valid ? rd_data_reg : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            left_reg      <= 8'd0;
            link_reg      <= LINK_NONE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg  <= phase_next;
                left_reg   <= left_next;
                link_reg   <= link_next;
                wr_ptr_reg <= wr_ptr_next;
                rd_ptr_reg <= rd_ptr_next;
            end
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                res_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
        if (move)
        begin
            out_reg <= res_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && do_write)
        begin
            queue_mem[wr_ptr_reg] <= req.line_byte;
        end
        if (accept && do_read)
        begin
            rd_data_reg <= queue_mem[rd_ptr_reg];
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.payload_valid = out_reg.payload_valid;
    assign rsp.payload_byte  = out_reg.payload_byte;
    assign rsp.frame_link    = out_reg.frame_link;
    assign rsp.dropped       = out_reg.dropped;
    assign rsp.read_valid    = out_reg.read_valid;
    assign rsp.read_data     = out_reg.read_data;

endmodule
